// ===== rtl/smc_pkg.sv =====
package smc_pkg;

    // Build defaults for the top-level parameters
    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_LINE_DEF    = 256;

    // Fixed field and register widths
    localparam int CHAR_W      = 8;
    localparam int PAT_CHARS   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = 9;
    localparam int TOT_W       = 16;
    localparam int LINE_W      = 16;
    localparam int POS_OUT_W   = 8;
    localparam int OUT_TDATA_W = 64;

    // Saturation limits
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [TOT_W-1:0]  TOT_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // Result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } cfg_index_t;

    // Result kinds
    typedef enum logic {
        KIND_MATCH   = 1'b0,
        KIND_SUMMARY = 1'b1
    } result_kind_t;

    // One result item
    typedef struct packed {
        logic                 last;
        result_kind_t         kind;
        logic [TOT_W-1:0]     total_matches;
        logic [CNT_W-1:0]     line_matches;
        logic [CNT_W-1:0]     match_ordinal;
        logic [POS_OUT_W-1:0] match_position;
        logic [LINE_W-1:0]    line_number;
    } result_t;

    // Up to two results written into the queue per accepted item
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } rq_push_t;

endpackage

// ===== rtl/smc_cell.sv =====
module smc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic                       clear,
    input  logic                       in_use,
    input  logic [smc_pkg::CHAR_W-1:0] d_in,
    input  logic [smc_pkg::CHAR_W-1:0] pat,
    output logic [smc_pkg::CHAR_W-1:0] q,
    output logic                       eq
);
    import smc_pkg::*;

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;

    // Incoming character is what this cell holds after the shift
    assign eq = !in_use || (d_in == pat);
    assign q  = char_reg;

    // Window slot: cleared at line end, loaded from d_in on a shift
    always_comb
    begin
        char_next = char_reg;
        if (clear)
        begin
            char_next = '0;
        end
        else if (shift)
        begin
            char_next = d_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg <= '0;
        end
        else
        begin
            char_reg <= char_next;
        end
    end

endmodule

// ===== rtl/smc_result_fifo.sv =====
module smc_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  smc_pkg::rq_push_t push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output smc_pkg::result_t  out_res
);
    import smc_pkg::*;

    result_t              mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  wr_ptr_reg;
    logic [RQ_PTR_W-1:0]  wr_ptr_next;
    logic [RQ_PTR_W-1:0]  rd_ptr_reg;
    logic [RQ_PTR_W-1:0]  rd_ptr_next;
    logic [RQ_CNT_W-1:0]  count_reg;
    logic [RQ_CNT_W-1:0]  count_next;
    logic                 pop;
    logic [RQ_PTR_W-1:0]  wr_ptr_plus1;

    // Room for the worst case of two results from one item
    assign room      = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + RQ_PTR_W'(1);

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.push0)
        begin
            wr_ptr_next = wr_ptr_plus1;
            count_next  = count_next + RQ_CNT_W'(1);
        end
        if (push.push1)
        begin
            wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(2);
            count_next  = count_next + RQ_CNT_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(1);
            count_next  = count_next - RQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            mem_reg[wr_ptr_plus1] <= push.res1;
        end
    end

endmodule

// ===== rtl/substring_match_counter_unit.sv =====
// Channel  | Direction | tdata                   | tuser       | tlast
// s_*      | in        | text_char               | has_char    | line_end
// m_*      | out       | line_number .. total    | result_kind | last_result
// cfg_*    | in        | write only: 0 length, 1 pattern low, 2 pattern high
//
// One item per cycle when not stalled: the window is a row of cells that shift
// and compare in the accepting cycle, and results go into a four-entry queue.
// A new item is taken while the queue holds at most two results. The queue
// drains one result per cycle when m_tready is high, so two-result items stall.
// A result is on m_* from the cycle after its item is accepted at the earliest.
// Reset clears window, match counts and pattern; line and length start at 1.
module substring_match_counter_unit #(
    parameter int MAX_PATTERN = smc_pkg::MAX_PATTERN_DEF,
    parameter int MAX_LINE    = smc_pkg::MAX_LINE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [smc_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] text_char
    input  logic [0:0]                      s_tuser,   // [0] has_char
    input  logic                            s_tlast,   // line_end
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] line_number, [23:16] match_position, [32:24] match_ordinal,
    // [41:33] line_matches, [57:42] total_matches, [63:58] zero
    output logic [smc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [0:0]                      m_tuser,   // [0] result_kind
    output logic                            m_tlast,   // last_result
    // Configuration
    input  logic                            cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import smc_pkg::*;

    localparam int PW = $clog2(MAX_LINE + 1);

    // Configuration registers
    logic [LEN_W-1:0]      len_reg;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;

    // Line state
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic [PW-1:0]     nas_reg;
    logic [PW-1:0]     nas_next;
    logic [CNT_W-1:0]  lm_reg;
    logic [CNT_W-1:0]  lm_next;
    logic [TOT_W-1:0]  tot_reg;
    logic [TOT_W-1:0]  tot_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;

    logic                 acc;
    logic                 store;
    logic                 hit;
    logic [LEN_W-1:0]     len_c;
    logic [PW-1:0]        p1;
    logic [PW-1:0]        len_ext;
    logic [PW-1:0]        start;
    logic [CHAR_W-1:0]    pat_bytes [PAT_CHARS];
    logic [CHAR_W-1:0]    pat_sel   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] in_use;
    logic [MAX_PATTERN-1:0] eq;
    logic [CHAR_W-1:0]    win       [MAX_PATTERN];
    rq_push_t             push;
    result_t              match_res;
    result_t              sum_res;
    result_t              out_res;

    assign acc   = s_tvalid && s_tready;
    assign store = s_tuser[0] && (pos_reg < PW'(MAX_LINE));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: len_reg      <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                default:            len_reg      <= len_reg;
            endcase
        end
    end

    // Effective length, clamped to the window depth
    assign len_c = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

    // Pattern character aligned to each cell: cell i holds pattern char len-1-i
    always_comb
    begin
        logic [LEN_W-1:0] pidx;
        for (int k = 0; k < PAT_CHARS / 2; k++)
        begin
            pat_bytes[k]                 = pat_low_reg[k*CHAR_W +: CHAR_W];
            pat_bytes[k + PAT_CHARS / 2] = pat_high_reg[k*CHAR_W +: CHAR_W];
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pidx       = len_c - LEN_W'(i) - LEN_W'(1);
            pat_sel[i] = pat_bytes[pidx[3:0]];
            in_use[i]  = (LEN_W'(i) < len_c);
        end
    end

    // Row of window cells
    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            logic [CHAR_W-1:0] d_in;
            if (g == 0)
            begin : g_head
                assign d_in = s_tdata;
            end
            else
            begin : g_tail
                assign d_in = win[g-1];
            end
            smc_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (acc && store),
                .clear  (acc && s_tlast),
                .in_use (in_use[g]),
                .d_in   (d_in),
                .pat    (pat_sel[g]),
                .q      (win[g]),
                .eq     (eq[g])
            );
        end
    endgenerate

    // Match decision
    assign p1      = pos_reg + PW'(1);
    assign len_ext = PW'(len_c);
    assign start   = p1 - len_ext;
    assign hit     = store && (len_c != '0) && (p1 >= len_ext) &&
                     (start >= nas_reg) && (&eq);

    // Saturating counters after this item's match
    always_comb
    begin
        lm_next  = lm_reg;
        tot_next = tot_reg;
        if (hit)
        begin
            if (lm_reg != CNT_MAX)
            begin
                lm_next = lm_reg + CNT_W'(1);
            end
            if (tot_reg != TOT_MAX)
            begin
                tot_next = tot_reg + TOT_W'(1);
            end
        end
    end

    // Result items
    always_comb
    begin
        match_res.last           = !s_tlast;
        match_res.kind           = KIND_MATCH;
        match_res.total_matches  = tot_next;
        match_res.line_matches   = lm_next;
        match_res.match_ordinal  = lm_next;
        match_res.match_position = POS_OUT_W'(start);
        match_res.line_number    = line_reg;

        sum_res.last             = 1'b1;
        sum_res.kind             = KIND_SUMMARY;
        sum_res.total_matches    = tot_next;
        sum_res.line_matches     = lm_next;
        sum_res.match_ordinal    = '0;
        sum_res.match_position   = '0;
        sum_res.line_number      = line_reg;

        push.push0 = acc && (hit || s_tlast);
        push.push1 = acc && hit && s_tlast;
        push.res0  = hit ? match_res : sum_res;
        push.res1  = sum_res;
    end

    // Next line state
    always_comb
    begin
        pos_next  = pos_reg;
        nas_next  = nas_reg;
        line_next = line_reg;
        if (s_tlast)
        begin
            pos_next = '0;
            nas_next = '0;
            if (line_reg != LINE_MAX)
            begin
                line_next = line_reg + LINE_W'(1);
            end
        end
        else
        begin
            if (store)
            begin
                pos_next = p1;
            end
            if (hit)
            begin
                nas_next = p1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            nas_reg  <= '0;
            lm_reg   <= '0;
            tot_reg  <= '0;
            line_reg <= LINE_W'(1);
        end
        else if (acc)
        begin
            pos_reg  <= pos_next;
            nas_reg  <= nas_next;
            lm_reg   <= s_tlast ? '0 : lm_next;
            tot_reg  <= tot_next;
            line_reg <= line_next;
        end
    end

    // Result queue
    smc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Output packing
    assign m_tdata = OUT_TDATA_W'({out_res.total_matches, out_res.line_matches,
                                   out_res.match_ordinal, out_res.match_position,
                                   out_res.line_number});
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ===== verif/substring_match_checker.sv =====
// Watches the text, result and register channels of the match counter,
// predicts the result items of each accepted text item and compares them
// in order with what comes out.
module substring_match_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [smc_pkg::CHAR_W-1:0]      s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [smc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [0:0]                      m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int unsigned                     fail_count,
    output int unsigned                     pending_results
);
    import smc_pkg::*;

    // Shadow registers
    logic [LEN_W-1:0]      pat_len;
    logic [CFG_DATA_W-1:0] pat_lo;
    logic [CFG_DATA_W-1:0] pat_hi;

    // Shadow of the search state
    logic [CHAR_W-1:0] window [PAT_CHARS];
    logic [CNT_W-1:0]  line_pos;
    logic [CNT_W-1:0]  next_start;
    logic [CNT_W-1:0]  line_cnt;
    logic [TOT_W-1:0]  total_cnt;
    logic [LINE_W-1:0] line_no;

    // Results still owed by the block, oldest first
    result_t owed_results [$];

    // Queue one result built from the current counters
    task automatic owe_result(input result_kind_t kind, input logic [POS_OUT_W-1:0] pos,
                              input logic [CNT_W-1:0] ord, input logic last);
        result_t r;
        r.last           = last;
        r.kind           = kind;
        r.total_matches  = total_cnt;
        r.line_matches   = line_cnt;
        r.match_ordinal  = ord;
        r.match_position = pos;
        r.line_number    = line_no;
        owed_results.push_back(r);
    endtask

    // Window shift, match test and line close for one text item
    task automatic predict_item(input logic [CHAR_W-1:0] ch, input logic has_char,
                                input logic line_end);
        int unsigned eff_len;
        int unsigned p;
        int unsigned start;
        bit          hit;
        logic [7:0]  pc;
        if (has_char && line_pos < MAX_LINE_DEF)
        begin
            eff_len = (pat_len > PAT_CHARS) ? PAT_CHARS : pat_len;
            p = 32'(line_pos);
            for (int i = PAT_CHARS - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = ch;
            line_pos  = CNT_W'(p + 1);
            if (eff_len > 0 && p + 1 >= eff_len)
            begin
                start = p + 1 - eff_len;
                hit   = (start >= next_start);
                for (int j = 0; j < eff_len; j++)
                begin
                    pc = (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
                    if (window[eff_len-1-j] != pc)
                        hit = 0;
                end
                if (hit)
                begin
                    if (line_cnt != CNT_MAX)
                        line_cnt++;
                    if (total_cnt != TOT_MAX)
                        total_cnt++;
                    next_start = CNT_W'(p + 1);
                    owe_result(KIND_MATCH, start[POS_OUT_W-1:0], line_cnt, !line_end);
                end
            end
        end
        if (line_end)
        begin
            owe_result(KIND_SUMMARY, '0, '0, 1'b1);
            foreach (window[i])
                window[i] = '0;
            line_pos   = '0;
            next_start = '0;
            line_cnt   = '0;
            if (line_no != LINE_MAX)
                line_no++;
        end
    endtask

    // Compare one result item with the oldest owed one
    task automatic compare_result(input result_t got);
        result_t want;
        if (owed_results.size() == 0)
        begin
            if (fail_count < 10)
                $display("unexpected result item: kind %0d line %0d pos %0d ord %0d",
                         got.kind, got.line_number, got.match_position, got.match_ordinal);
            fail_count++;
        end
        else
        begin
            want = owed_results.pop_front();
            if (got.kind != want.kind || got.line_number != want.line_number ||
                got.match_position != want.match_position ||
                got.match_ordinal != want.match_ordinal ||
                got.line_matches != want.line_matches ||
                got.total_matches != want.total_matches || got.last != want.last)
            begin
                if (fail_count < 10)
                begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected kind %0d line %0d pos %0d ord %0d lm %0d tot %0d last %0d",
                             want.kind, want.line_number, want.match_position,
                             want.match_ordinal, want.line_matches, want.total_matches,
                             want.last);
                    $display("  actual   kind %0d line %0d pos %0d ord %0d lm %0d tot %0d last %0d",
                             got.kind, got.line_number, got.match_position,
                             got.match_ordinal, got.line_matches, got.total_matches,
                             got.last);
                end
                fail_count++;
            end
        end
    endtask

    // Sample all channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        if (!rst_n)
        begin
            pat_len = LEN_W'(1);
            pat_lo  = '0;
            pat_hi  = '0;
            foreach (window[i])
                window[i] = '0;
            line_pos   = '0;
            next_start = '0;
            line_cnt   = '0;
            total_cnt  = '0;
            line_no    = LINE_W'(1);
            owed_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
                    CFG_PATTERN_LOW:    pat_lo  = cfg_data;
                    CFG_PATTERN_HIGH:   pat_hi  = cfg_data;
                    default: ;
                endcase
            end
            // results appear no earlier than the cycle after their item is taken, so compare first
            if (m_tvalid && m_tready)
            begin
                got.line_number    = m_tdata[15:0];
                got.match_position = m_tdata[23:16];
                got.match_ordinal  = m_tdata[32:24];
                got.line_matches   = m_tdata[41:33];
                got.total_matches  = m_tdata[57:42];
                got.kind           = result_kind_t'(m_tuser[0]);
                got.last           = m_tlast;
                compare_result(got);
            end
            if (s_tvalid && s_tready)
                predict_item(s_tdata, s_tuser[0], s_tlast);
        end
        pending_results = owed_results.size();
    end

endmodule

// ===== verif/substring_match_counter_unit_tb.sv =====
module substring_match_counter_unit_tb;
    import smc_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata;
    logic [0:0]             s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int unsigned            fail_count;
    int unsigned            pending_results;

    // Stimulus control
    bit          tx_idle;
    bit          rx_idle;
    bit          hold_results;
    int unsigned text_items;
    int unsigned pat_len_set;
    logic [7:0]  pat_chars [PAT_CHARS];
    logic [7:0]  alphabet [2];

    substring_match_counter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    substring_match_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(8 * 1_200_000);
        $display("FAILURE");
        $finish;
    end

    // Result receiver: random stalls, plus one long hold on request
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_results && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    // Offer one text item and wait for it to be taken; called at a falling edge
    task automatic send_item(input logic [7:0] ch, input logic has_char, input logic line_end);
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= has_char;
        s_tlast  <= line_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (has_char || line_end)
            text_items++;
    endtask

    // Let every owed result arrive, then allow the pipeline to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Load length and the sixteen pattern characters held in pat_chars
    task automatic apply_setting(input int unsigned len);
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        wait_idle();
        for (int j = 0; j < 8; j++)
        begin
            lo[8*j +: 8] = pat_chars[j];
            hi[8*j +: 8] = pat_chars[j+8];
        end
        pat_len_set = len;
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
    endtask

    // One line built mostly from pattern copies and pattern letters
    task automatic send_random_line();
        logic [7:0]  line_q [$];
        int unsigned n;
        int unsigned eff_len;
        int unsigned r;
        bit          bare_end;
        eff_len = (pat_len_set > PAT_CHARS) ? PAT_CHARS : pat_len_set;
        if (eff_len == 0)
            eff_len = $urandom_range(1, PAT_CHARS);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 40);
        while (line_q.size() < n)
        begin
            r = $urandom_range(0, 7);
            if (r < 2)
            begin
                for (int k = 0; k < eff_len; k++)
                    line_q.push_back(pat_chars[k]);
            end
            else if (r == 2)
            begin
                // broken copy: a prefix only
                for (int k = 0; k < $urandom_range(0, eff_len - 1); k++)
                    line_q.push_back(pat_chars[k]);
            end
            else
            begin
                r = $urandom_range(0, 19);
                line_q.push_back((r < 9) ? alphabet[0] : (r < 18) ? alphabet[1] : 8'($urandom));
            end
        end
        bare_end = (line_q.size() == 0) || ($urandom_range(0, 3) == 0);
        foreach (line_q[i])
        begin
            if ($urandom_range(0, 29) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(line_q[i], 1'b1, !bare_end && (i == line_q.size() - 1));
        end
        if (bare_end)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Stimulus and verdict
    initial
    begin
        int unsigned len_list [10];
        int unsigned len;
        int unsigned eff_len;
        len_list = '{1, 16, 0, 2, 3, 31, 17, 4, 8, 0};
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        s_tlast      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_PATTERN_LENGTH;
        cfg_data     = '0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_results = 1'b0;
        text_items   = 0;
        pat_len_set  = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: length 1, pattern of zero bytes
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hA5, 1'b0, 1'b1);

        // Full length pattern of all-ones bytes; match and line end together
        foreach (pat_chars[j])
            pat_chars[j] = 8'hFF;
        apply_setting(16);
        for (int i = 0; i < 16; i++)
            send_item(8'hFF, 1'b1, i == 15);

        // Zero length never matches
        foreach (pat_chars[j])
            pat_chars[j] = 8'h00;
        apply_setting(0);
        send_item(8'h00, 1'b1, 1'b1);

        // Random phases over a spread of settings
        for (int s = 0; s < 10; s++)
        begin
            len = (s == 9) ? $urandom_range(0, 31) : len_list[s];
            eff_len = (len > PAT_CHARS) ? PAT_CHARS : len;
            if (s == 1)
            begin
                alphabet[0] = 8'h00;
                alphabet[1] = 8'hFF;
            end
            else
            begin
                alphabet[0] = 8'($urandom);
                alphabet[1] = 8'($urandom);
            end
            foreach (pat_chars[j])
            begin
                if (j < eff_len && $urandom_range(0, 7) != 0)
                    pat_chars[j] = alphabet[$urandom_range(0, 1)];
                else
                    pat_chars[j] = 8'($urandom);
            end
            apply_setting(len);
            tx_idle = (s != 3) && (s != 6);
            rx_idle = (s != 6);
            if (s == 3)
                hold_results = 1'b1;
            text_items = 0;
            while (text_items < 165)
            begin
                send_random_line();
                if (s == 5 && text_items >= 90 && text_items < 130)
                    wait_idle();
            end
        end

        // Back-to-back items that each give a match and a summary, no idling
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        foreach (pat_chars[j])
            pat_chars[j] = 8'($urandom);
        pat_chars[0] = 8'h5A;
        apply_setting(1);
        for (int i = 0; i < 60; i++)
            send_item(8'h5A, 1'b1, 1'b1);

        wait_idle();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/smc_pkg.sv
rtl/smc_cell.sv
rtl/smc_result_fifo.sv
rtl/substring_match_counter_unit.sv
verif/substring_match_checker.sv
verif/substring_match_counter_unit_tb.sv
